/* sv/pons_pkg.sv */
// shared constants and types for the pitch to octave/note splitter
`timescale 1ns / 1ps
`default_nettype none

package pons_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_NOTES_DEF = 34;

  // fixed field widths
  localparam int VIN_W      = 21;
  localparam int OCT_OUT_W  = 5;
  localparam int NOTE_W     = 23;
  localparam int INTV_W     = 20;
  localparam int NOTE_SEL_W = 6;
  localparam int OCT_SEL_W  = 4;
  localparam int NPO_W      = 6;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  localparam logic [NPO_W-1:0] NPO_RESET = NPO_W'(12);
  localparam int OCT_SEL_LIMIT = 5;
  localparam int VOLT_LIMIT    = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOTE_SELECT   = 2'd0,
    CFG_OCTAVE_SELECT = 2'd1,
    CFG_NOTES_PER_OCT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* sv/pons_div.sv */
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module pons_div import pons_pkg::*; #(
  parameter int QW = FRAC_BITS_DEF,
  parameter int DW = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,  // must be below divisor
  input  wire logic [DW-1:0] divisor_i,
  output div_stat_t          stat_o,
  output logic      [QW-1:0] quo_o
);

  localparam int CW = $clog2(QW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [DW:0]   shifted;
  logic          fits;

  assign shifted = {rem_q, 1'b0};
  assign fits    = shifted >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? DW'(shifted - {1'b0, divisor_i}) : DW'(shifted);
      quo_d = {quo_q[QW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

/* sv/pons_mode.sv */
// rounding mode state: button edge toggle, cleared on size change
`timescale 1ns / 1ps
`default_nettype none

module pons_mode import pons_pkg::*; #(
  parameter int SW = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          update_i,
  input  wire logic          button_i,
  input  wire logic [SW-1:0] size_i,
  output logic               round_o
);

  logic          btn_prev_q, btn_prev_d;
  logic          round_q, round_d;
  logic [SW-1:0] size_seen_q, size_seen_d;

  always_comb begin
    btn_prev_d  = btn_prev_q;
    round_d     = round_q;
    size_seen_d = size_seen_q;
    if (update_i) begin
      btn_prev_d = button_i;
      if (button_i && !btn_prev_q) begin
        round_d = ~round_q;
      end
      // size change wins over a toggle in the same beat
      if (size_seen_q != size_i) begin
        round_d     = 1'b0;
        size_seen_d = size_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_prev_q  <= 1'b0;
      round_q     <= 1'b0;
      size_seen_q <= '0;
    end else begin
      btn_prev_q  <= btn_prev_d;
      round_q     <= round_d;
      size_seen_q <= size_seen_d;
    end
  end

  assign round_o = round_q;

endmodule

`default_nettype wire

/* sv/pitch_to_octave_note_splitter.sv */
// top level of the pitch to octave/note splitter
`timescale 1ns / 1ps
`default_nettype none

// Splits a signed fixed point pitch (FRAC_BITS fraction bits, one volt per
// octave) into a floor octave and a note position, the fraction times the
// notes per octave, also fixed point. With rounding on, the note is rounded
// half up to a whole note; a note above size minus one half wraps into the
// next octave, so the note may come out slightly negative. Rounding toggles
// on each rising edge of the button level carried with an input beat and
// is cleared whenever the clamped notes-per-octave size differs from the last one
// seen (always so on the first beat after reset). A beat may select the
// internal source instead: octave_select plus note_select over size, with
// the quotient formed by a serial divider, one bit per cycle. Every beat
// produces one output beat, and the internal voltage is reported on each.
// Sequence: an accepted item passes the states DIV, where the serial divider
// runs, MUL and FIN, then the block returns to IDLE for the next accept;
// s_axis_tready is low meanwhile. A finished result sits in the output
// register, so the next item is accepted while it waits.
// Configuration writes are always taken and must only be issued while idle.

module pitch_to_octave_note_splitter import pons_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_NOTES = MAX_NOTES_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // config write channel
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // voltage_in[20:0], button_level[21]
  input  wire logic                   s_axis_tuser,   // use_internal
  // output stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // octave_out[4:0], note_out[27:5],
                                                      // internal_voltage[47:28], rounding_on[48]
);

  localparam int SW  = $clog2(MAX_NOTES + 1);         // size width
  localparam int IW  = FRAC_BITS + OCT_SEL_W;          // internal voltage width
  localparam int VW  = ((VIN_W > FRAC_BITS + 5) ? VIN_W : FRAC_BITS + 5) + 1;
  localparam int OW  = VW - FRAC_BITS;                  // octave width
  localparam int PW  = FRAC_BITS + SW + 1;              // note product width
  localparam logic signed [VW-1:0] VLIM = VW'(VOLT_LIMIT * (2 ** FRAC_BITS));
  localparam logic [PW-1:0]        HALF = PW'(2 ** (FRAC_BITS - 1));

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [NOTE_SEL_W-1:0]       note_sel_q;
  logic signed [OCT_SEL_W-1:0] oct_sel_q;
  logic [NPO_W-1:0]            npo_q;

  // latched input beat
  logic                        use_int_q;
  logic signed [VIN_W-1:0]     vin_q;

  // working registers
  logic signed [OW-1:0]        oct_q;
  logic [FRAC_BITS+SW-1:0]     prod_q;
  logic signed [IW-1:0]        intv_q;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0]      out_data_q;

  logic                        in_beat, out_load;
  logic [SW-1:0]               size;
  logic [SW-1:0]               pitch;
  logic signed [OCT_SEL_W-1:0] oct_c;
  logic                        round_mode;
  div_stat_t                   div_stat;
  logic [FRAC_BITS-1:0]        quo;
  logic signed [IW-1:0]        intv;
  logic signed [VW-1:0]        vin_ext, vin_sat;
  logic [PW-1:0]               rnd_sum, sc, thr, size_one;
  logic                        wrap;
  logic signed [PW:0]          note_s;
  logic signed [OW-1:0]        oct_fin;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_sel_q <= '0;
      oct_sel_q  <= '0;
      npo_q      <= NPO_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_NOTE_SELECT:   note_sel_q <= cfg_data_i[NOTE_SEL_W-1:0];
        CFG_OCTAVE_SELECT: oct_sel_q  <= cfg_data_i[OCT_SEL_W-1:0];
        CFG_NOTES_PER_OCT: npo_q      <= cfg_data_i[NPO_W-1:0];
        default: ;
      endcase
    end
  end

  // size clamped to 1..MAX_NOTES, note and octave selects clamped
  always_comb begin
    if (npo_q == '0) begin
      size = SW'(1);
    end else if (npo_q > NPO_W'(MAX_NOTES)) begin
      size = SW'(MAX_NOTES);
    end else begin
      size = SW'(npo_q);
    end
    if (note_sel_q >= NOTE_SEL_W'(size)) begin
      pitch = size - 1'b1;
    end else begin
      pitch = SW'(note_sel_q);
    end
    if (oct_sel_q < -OCT_SEL_W'(OCT_SEL_LIMIT)) begin
      oct_c = -OCT_SEL_W'(OCT_SEL_LIMIT);
    end else if (oct_sel_q > OCT_SEL_W'(OCT_SEL_LIMIT)) begin
      oct_c = OCT_SEL_W'(OCT_SEL_LIMIT);
    end else begin
      oct_c = oct_sel_q;
    end
  end

  pons_mode #(
    .SW(SW)
  ) u_mode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .update_i(in_beat),
    .button_i(s_axis_tdata[VIN_W]),
    .size_i  (size),
    .round_o (round_mode)
  );

  // pitch / size is below one, so the quotient is the fraction alone
  pons_div #(
    .QW(FRAC_BITS),
    .DW(SW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_beat),
    .dividend_i(pitch),
    .divisor_i (size),
    .stat_o    (div_stat),
    .quo_o     (quo)
  );

  assign intv = {oct_c, quo};

  // source select and saturation to plus or minus the voltage limit
  always_comb begin
    if (use_int_q) begin
      vin_ext = VW'(intv);
    end else begin
      vin_ext = VW'(vin_q);
    end
    if (vin_ext > VLIM) begin
      vin_sat = VLIM;
    end else if (vin_ext < -VLIM) begin
      vin_sat = -VLIM;
    end else begin
      vin_sat = vin_ext;
    end
  end

  // rounding, then wrap of a note above size minus one half
  always_comb begin
    size_one = PW'({size, {FRAC_BITS{1'b0}}});
    rnd_sum  = {1'b0, prod_q} + HALF;
    if (round_mode) begin
      sc = {rnd_sum[PW-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
    end else begin
      sc = {1'b0, prod_q};
    end
    thr     = size_one - HALF;
    wrap    = sc > thr;
    note_s  = $signed({1'b0, sc}) - (wrap ? $signed({1'b0, size_one}) : '0);
    oct_fin = oct_q + (wrap ? OW'(1) : OW'(0));
  end

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_beat)                 state_d = ST_DIV;
      ST_DIV:  if (div_stat.done)           state_d = ST_MUL;
      ST_MUL:                               state_d = ST_FIN;
      ST_FIN:  if (out_load)                state_d = ST_IDLE;
      default:                              state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      vin_q     <= s_axis_tdata[VIN_W-1:0];
      use_int_q <= s_axis_tuser;
    end
    if (state_q == ST_MUL) begin
      oct_q  <= vin_sat[VW-1:FRAC_BITS];
      prod_q <= (FRAC_BITS + SW)'(vin_sat[FRAC_BITS-1:0]) * (FRAC_BITS + SW)'(size);
      intv_q <= intv;
    end
    if (out_load) begin
      out_data_q <= {
        (OUT_TDATA_W - OCT_OUT_W - NOTE_W - INTV_W - 1)'(0),
        round_mode,
        INTV_W'(intv_q),
        NOTE_W'(note_s),
        OCT_OUT_W'(oct_fin)
      };
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
